// ----- sv/stk_alloc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stack allocator package
// Field widths, command and status codes shared by the allocator's files.
// ----------------------------------------------------------------------------
package stk_alloc_pkg;

	localparam int unsigned DATA_W   = 32;   // size, alignment and address fields
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned RECORDS_W = 11;  // width of the records_in_use field
	localparam int unsigned PADDR_W  = 3;    // two registers at byte offsets 0 and 4
	localparam int unsigned REC_W    = 2 * DATA_W;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Register index on the configuration port (address bit 2).
	localparam logic REG_HEAP_BASE = 1'b0;
	localparam logic REG_HEAP_SIZE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK         = 2'd0,
		STATUS_OUT_OF_MEM = 2'd1,
		STATUS_STACK_FULL = 2'd2,
		STATUS_EMPTY      = 2'd3
	} status_t;

endpackage

`default_nettype wire

// ----- sv/stk_alloc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stack allocator RAM
// Simple dual-port RAM, one write and one read port, read data registered.
// ----------------------------------------------------------------------------
module stk_alloc_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [AW-1:0]             waddr,
	input  wire logic [WIDTH-1:0]          wdata,
	input  wire logic                      re,
	input  wire logic [AW-1:0]             raddr,
	output logic      [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/stack_allocator_with_record_stack.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stack allocator with record stack
// Bump allocator over one managed region, with a LIFO of allocation records.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. The transfer edge
// of a free command issues the read of the top record from the record RAM,
// ST_STEP aligns the frame pointer (or unwinds it by the popped record) while
// that registered read arrives, and ST_FINISH does the limit check and
// updates the frame pointer, record count and RAM. busy falls after that,
// so a new command can be taken only once the current one has finished. The
// result appears for exactly one cycle with done high, in the cycle after the
// closing edge; the receiver cannot hold it off. The record RAM needs no
// clearing pass after reset, and writing heap_base empties the record stack.
// ----------------------------------------------------------------------------
module stack_allocator_with_record_stack #(
	parameter int unsigned RECORD_DEPTH = 1024,
	parameter int unsigned ADDRESS_BITS = 32
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// command channel
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic                                   command,
	input  wire logic [stk_alloc_pkg::DATA_W-1:0]       request_size,
	input  wire logic [stk_alloc_pkg::DATA_W-1:0]       request_alignment,
	// result channel
	output logic                                        done,
	output logic [stk_alloc_pkg::STATUS_W-1:0]          status,
	output logic [stk_alloc_pkg::DATA_W-1:0]            block_address,
	output logic [stk_alloc_pkg::DATA_W-1:0]            frame_pointer,
	output logic [stk_alloc_pkg::RECORDS_W-1:0]         records_in_use,
	// configuration port
	input  wire logic                                   psel,
	input  wire logic                                   penable,
	input  wire logic                                   pwrite,
	input  wire logic [stk_alloc_pkg::PADDR_W-1:0]      paddr,
	input  wire logic [stk_alloc_pkg::DATA_W-1:0]       pwdata,
	output logic [stk_alloc_pkg::DATA_W-1:0]            prdata,
	output logic                                        pready
);

	localparam int unsigned DW  = stk_alloc_pkg::DATA_W;
	localparam int unsigned AW_EXT = (ADDRESS_BITS > DW) ? ADDRESS_BITS : DW;
	// Two guard bits so that alignment and end sums never wrap.
	localparam int unsigned W   = AW_EXT + 2;
	localparam int unsigned CW  = $clog2(RECORD_DEPTH + 1);
	localparam int unsigned IW  = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
	localparam logic [W-1:0] ADDR_MAX_W = {{(W-ADDRESS_BITS){1'b0}}, {ADDRESS_BITS{1'b1}}};
	localparam logic [DW-1:0] BASE_MASK = (ADDRESS_BITS >= DW) ? {DW{1'b1}}
		: DW'((64'd1 << ADDRESS_BITS) - 64'd1);
	localparam logic [CW-1:0] DEPTH_C = CW'(RECORD_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_STEP   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t                   state_q;
	logic [DW-1:0]            base_q;
	logic [DW-1:0]            size_q;
	logic [ADDRESS_BITS-1:0]  frame_q;
	logic [CW-1:0]            count_q;

	logic                     cmd_q;
	logic [DW-1:0]            req_size_q;
	logic [DW-1:0]            req_align_q;

	logic [W-1:0]             sum_s1;     // aligned start, or unwound pointer before masking
	logic [DW-1:0]            mask_s1;
	logic [W-1:0]             limit_s1;
	logic                     under_s1;
	logic                     full_s1;

	logic                     done_q;
	stk_alloc_pkg::status_t   status_q;
	logic [DW-1:0]            block_q;
	logic [DW-1:0]            frame_out_q;
	logic [CW-1:0]            count_out_q;

	logic                     accept;
	logic                     cfg_wr;
	logic                     ram_we;
	logic                     ram_re;
	logic [IW-1:0]            ram_waddr;
	logic [IW-1:0]            ram_raddr;
	logic [stk_alloc_pkg::REC_W-1:0] ram_wdata;
	logic [stk_alloc_pkg::REC_W-1:0] ram_rdata;

	logic [DW-1:0]            align_eff;
	logic [DW-1:0]            amask;
	logic [DW-1:0]            fmask;
	logic [DW-1:0]            rsize;
	logic [W-1:0]             frame_w;
	logic [W-1:0]             lim_sum;
	logic [W-1:0]             step_sum;
	logic                     step_under;

	logic [W-1:0]             end_w;
	logic [W-1:0]             unwound;
	logic [W-1:0]             nf_w;
	stk_alloc_pkg::status_t   status_nx;
	logic [ADDRESS_BITS-1:0]  frame_nx;
	logic [CW-1:0]            count_nx;
	logic [DW-1:0]            block_nx;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		case (paddr[2])
			stk_alloc_pkg::REG_HEAP_BASE: prdata = base_q;
			stk_alloc_pkg::REG_HEAP_SIZE: prdata = size_q;
			default:                      prdata = '0;
		endcase
	end

	// The top record is read on the transfer edge of a free command.
	assign ram_re    = accept && (command == stk_alloc_pkg::CMD_FREE);
	assign ram_raddr = IW'(count_q - CW'(1));

	// ------------------------------------------------------------------ step
	assign align_eff = (req_align_q == '0) ? DW'(1) : req_align_q;
	assign amask     = align_eff - DW'(1);
	assign rsize     = ram_rdata[DW-1:0];
	assign fmask     = ram_rdata[2*DW-1:DW] - DW'(1);
	assign frame_w   = W'(frame_q);
	assign lim_sum   = W'(base_q) + W'(size_q);

	always_comb begin
		step_under = 1'b0;
		if (cmd_q == stk_alloc_pkg::CMD_ALLOC) begin
			step_sum = (frame_w + W'(amask)) & ~W'(amask);
		end else begin
			step_under = W'(rsize) > frame_w;
			step_sum   = frame_w - W'(rsize) + W'(fmask);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_STEP) begin
			sum_s1   <= step_sum;
			under_s1 <= step_under;
			mask_s1  <= (cmd_q == stk_alloc_pkg::CMD_ALLOC) ? amask : fmask;
			limit_s1 <= (lim_sum > ADDR_MAX_W) ? ADDR_MAX_W : lim_sum;
			full_s1  <= count_q >= DEPTH_C;
		end
	end

	// ---------------------------------------------------------------- finish
	assign end_w   = sum_s1 + W'(req_size_q);
	assign unwound = sum_s1 & ~W'(mask_s1);

	always_comb begin
		nf_w      = unwound;
		status_nx = stk_alloc_pkg::STATUS_OK;
		frame_nx  = frame_q;
		count_nx  = count_q;
		block_nx  = '0;
		ram_we    = 1'b0;
		if (cmd_q == stk_alloc_pkg::CMD_ALLOC) begin
			if (end_w > limit_s1) begin
				status_nx = stk_alloc_pkg::STATUS_OUT_OF_MEM;
			end else if (full_s1) begin
				status_nx = stk_alloc_pkg::STATUS_STACK_FULL;
			end else begin
				frame_nx = ADDRESS_BITS'(end_w);
				count_nx = count_q + CW'(1);
				block_nx = DW'(sum_s1);
				ram_we   = (state_q == ST_FINISH);
			end
		end else if (count_q == '0) begin
			status_nx = stk_alloc_pkg::STATUS_EMPTY;
		end else begin
			// A record larger than the pointer, or an unwind below the base,
			// lands on the base; anything above the address space saturates.
			if (under_s1 || (unwound < W'(base_q))) begin
				nf_w = W'(base_q);
			end else if (unwound > ADDR_MAX_W) begin
				nf_w = ADDR_MAX_W;
			end
			frame_nx = ADDRESS_BITS'(nf_w);
			count_nx = count_q - CW'(1);
		end
	end

	assign ram_waddr = IW'(count_q);
	assign ram_wdata = {align_eff, req_size_q};

	stk_alloc_ram #(
		.WIDTH (stk_alloc_pkg::REC_W),
		.DEPTH (RECORD_DEPTH)
	) u_record_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ---------------------------------------------------------------- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			base_q  <= '0;
			size_q  <= '0;
			frame_q <= '0;
			count_q <= '0;
		end else begin
			done_q <= (state_q == ST_FINISH);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cfg_wr && (paddr[2] == stk_alloc_pkg::REG_HEAP_BASE)) begin
				base_q  <= pwdata & BASE_MASK;
				frame_q <= ADDRESS_BITS'(pwdata & BASE_MASK);
				count_q <= '0;
			end else if (state_q == ST_FINISH) begin
				frame_q <= frame_nx;
				count_q <= count_nx;
			end
			if (cfg_wr && (paddr[2] == stk_alloc_pkg::REG_HEAP_SIZE)) begin
				size_q <= pwdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q       <= command;
			req_size_q  <= request_size;
			req_align_q <= request_alignment;
		end
		if (state_q == ST_FINISH) begin
			status_q    <= status_nx;
			block_q     <= block_nx;
			frame_out_q <= DW'(frame_nx);
			count_out_q <= count_nx;
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign block_address  = block_q;
	assign frame_pointer  = frame_out_q;
	assign records_in_use = stk_alloc_pkg::RECORDS_W'(count_out_q);

	// ------------------------------------------------------------- assertions
	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FINISH))
		else $error("result strobe without a closing cycle");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("record count exceeds the record stack depth");

	a_fail_no_address: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != stk_alloc_pkg::STATUS_OK)) |-> (block_address == '0))
		else $error("failed command returned a block address");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy && (state_q == ST_STEP)))
		else $error("command transfer did not start the sequence");

	a_write_in_finish: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ((state_q == ST_FINISH) && (count_q < DEPTH_C)))
		else $error("record write outside the closing cycle or into a full stack");

endmodule

`default_nettype wire
